// ===== sv/lmst_pkg.sv =====
`timescale 1ns / 1ps
package lmst_pkg;

	localparam int NUM_SYMBOLS      = 37;
	localparam int MAX_SYMBOL_BYTES = 6;
	localparam int PCNT_W           = 3;
	localparam int SLEN_W           = 3;
	localparam int LINE_W           = 16;
	localparam int COL_W            = 16;
	localparam int OFF_W            = 24;
	localparam int LEN_W            = 16;
	localparam int KIND_W           = 6;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [KIND_W-1:0] KIND_END      = 6'd0;
	localparam logic [KIND_W-1:0] KIND_IDENT    = 6'd1;
	localparam logic [KIND_W-1:0] KIND_NUMBER   = 6'd2;
	localparam logic [KIND_W-1:0] KIND_LITERAL  = 6'd3;
	localparam logic [KIND_W-1:0] KIND_SYM_BASE = 6'd4;
	localparam logic [KIND_W-1:0] KIND_SYM_LAST = 6'd40;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_ALPHA,
		CLS_DIGIT,
		CLS_UNDER,
		CLS_IDPUNCT,
		CLS_SPACE,
		CLS_NEWLINE,
		CLS_HASH
	} cls_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_COMMENT
	} mode_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_mark;
	} src_item_t;

	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
	} pend_t;

	typedef struct packed {
		pend_t ch;
		logic  fin;
	} q_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [LINE_W-1:0] start_line;
		logic [COL_W-1:0]  start_column;
		logic [OFF_W-1:0]  start_offset;
		logic [LEN_W-1:0]  token_length;
		logic              last_token;
	} tok_item_t;

	localparam logic [SLEN_W-1:0] SYM_LEN [NUM_SYMBOLS] = '{
		3'd6, 3'd5, 3'd5, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd1, 3'd1
	};

	localparam logic [7:0] SYM_BYTES [NUM_SYMBOLS][MAX_SYMBOL_BYTES] = '{
		'{8'hC2, 8'hAB, 8'hC2, 8'hAB, 8'hC2, 8'hAB},
		'{8'hC2, 8'hAB, 8'hC2, 8'hAB, 8'h2D, 8'h00},
		'{8'hC2, 8'hAB, 8'hC2, 8'hAB, 8'h2B, 8'h00},
		'{8'hC2, 8'hAB, 8'hC2, 8'hAB, 8'hC2, 8'hB7},
		'{8'hC2, 8'hAB, 8'hC2, 8'hAB, 8'h3A, 8'h00},
		'{8'hC2, 8'hAB, 8'hC2, 8'hAB, 8'h25, 8'h00},
		'{8'hC2, 8'hB6, 8'hC2, 8'hB6, 8'h00, 8'h00},
		'{8'hC2, 8'hB6, 8'h3D, 8'h00, 8'h00, 8'h00},
		'{8'hC2, 8'hA2, 8'h21, 8'h00, 8'h00, 8'h00},
		'{8'h21, 8'hC2, 8'hA2, 8'h00, 8'h00, 8'h00},
		'{8'hE2, 8'h80, 8'hA6, 8'h00, 8'h00, 8'h00},
		'{8'hE2, 8'h80, 8'h99, 8'h00, 8'h00, 8'h00},
		'{8'hE2, 8'h8A, 8'h95, 8'h00, 8'h00, 8'h00},
		'{8'h3B, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC2, 8'hBB, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC2, 8'hAB, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC5, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC2, 8'hA8, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC2, 8'hB6, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC2, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC2, 8'hA7, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC3, 8'hB8, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'hC3, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h5B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h5D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h7D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h7C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h27, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h24, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h5E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	function automatic cls_t byte_class(input logic [7:0] b);
		cls_t c;
		if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
			c = CLS_ALPHA;
		end else if (b >= 8'h30 && b <= 8'h39) begin
			c = CLS_DIGIT;
		end else if (b == CH_UNDER) begin
			c = CLS_UNDER;
		end else if (b == CH_DASH || b == CH_DOT) begin
			c = CLS_IDPUNCT;
		end else if (b == CH_NL) begin
			c = CLS_NEWLINE;
		end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
			c = CLS_SPACE;
		end else if (b == CH_HASH) begin
			c = CLS_HASH;
		end else begin
			c = CLS_OTHER;
		end
		return c;
	endfunction

	function automatic logic ident_cont(input cls_t c);
		return c == CLS_ALPHA || c == CLS_DIGIT || c == CLS_UNDER || c == CLS_IDPUNCT;
	endfunction

endpackage

// ===== sv/longest_match_symbol_tokenizer_top.sv =====
`timescale 1ns / 1ps
// A token is registered for output once the back end resolves the byte that closes it.
// Throughput: one byte per cycle while the resolve engine is not busy and the output is not
// stalled; a run that ends, and each byte released from a held symbol prefix beyond the first,
// need resolve steps of their own; the end token comes after held bytes and runs resolve.
// Reset (arst_n low, asynchronous) empties the queue, sets line and column to 1, offset to 0.
module longest_match_symbol_tokenizer_top #(
	parameter int Q_DEPTH = lmst_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  lmst_pkg::src_item_t src_item,
	output logic                tok_valid,
	input  logic                tok_stall,
	output lmst_pkg::tok_item_t tok_item
);
	import lmst_pkg::*;

	logic    q_valid, q_pop;
	q_item_t q_item;

	lmst_front #(.DEPTH(Q_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	lmst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_item  (tok_item)
	);

endmodule

// ===== sv/lmst_front.sv =====
`timescale 1ns / 1ps
module lmst_front #(
	parameter int DEPTH = lmst_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  lmst_pkg::src_item_t src_item,
	output logic                q_valid,
	input  logic                q_pop,
	output lmst_pkg::q_item_t   q_item
);
	import lmst_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr, rd;
	q_item_t          wr_item;

	assign src_stall = (count_q == CNT_W'(DEPTH));
	assign q_valid   = (count_q != '0);
	assign q_item    = mem_q[rd_ptr_q];
	assign wr        = src_valid && !src_stall;
	assign rd        = q_pop && q_valid;

	// classify on entry so the back end sees the byte class with the byte
	always_comb begin
		wr_item.ch.data = src_item.byte_in;
		wr_item.ch.cls  = byte_class(src_item.byte_in);
		wr_item.fin     = src_item.end_mark;
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lmst_back.sv =====
`timescale 1ns / 1ps
module lmst_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  lmst_pkg::q_item_t   q_item,
	output logic                q_pop,
	output logic                tok_valid,
	input  logic                tok_stall,
	output lmst_pkg::tok_item_t tok_item
);
	import lmst_pkg::*;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_RUN_ADV,
		ACT_RUN_END,
		ACT_CMT_ADV,
		ACT_CMT_END,
		ACT_HOLD,
		ACT_SYM,
		ACT_SPACE,
		ACT_NEWLINE,
		ACT_HASH,
		ACT_START_ID,
		ACT_START_NUM,
		ACT_LITERAL,
		ACT_FLUSH_RUN,
		ACT_END_TOK,
		ACT_END_START
	} act_t;

	pend_t             pend_q [MAX_SYMBOL_BYTES];
	logic [PCNT_W-1:0] pcnt_q;
	mode_t             mode_q;
	logic              busy_q, final_q;
	logic [LINE_W-1:0] line_q, run_line_q;
	logic [COL_W-1:0]  col_q, run_col_q;
	logic [OFF_W-1:0]  off_q, run_off_q;
	logic [LEN_W-1:0]  run_len_q;

	pend_t             pend_d [MAX_SYMBOL_BYTES];
	logic [PCNT_W-1:0] pcnt_d;
	mode_t             mode_d;
	logic              busy_d, final_d;
	logic [LINE_W-1:0] line_d, run_line_d;
	logic [COL_W-1:0]  col_d, run_col_d;
	logic [OFF_W-1:0]  off_d, run_off_d;
	logic [LEN_W-1:0]  run_len_d;

	tok_item_t         tok_q;
	logic              tok_valid_q;

	pend_t             pe [MAX_SYMBOL_BYTES];
	pend_t             c;
	logic [PCNT_W-1:0] n_eff;
	logic              appending, start_end, active;
	logic              hold, hit_found;
	logic [KIND_W-1:0] hit_idx;
	logic [SLEN_W-1:0] hit_len;
	act_t              act;
	logic              emit_v;
	tok_item_t         emit_item;
	logic              advance, out_room;
	logic [SLEN_W-1:0] step_k;
	logic [PCNT_W-1:0] drop_k;
	logic [COL_W:0]    col_sum;
	logic [COL_W-1:0]  col_adv;
	logic [OFF_W-1:0]  off_adv;

	assign appending = !busy_q && q_valid && !q_item.fin;
	assign start_end = !busy_q && q_valid && q_item.fin;
	assign active    = busy_q || appending;

	// pending window with the incoming byte placed after the held ones
	always_comb begin
		for (int j = 0; j < MAX_SYMBOL_BYTES; j++) begin
			pe[j] = (appending && pcnt_q == PCNT_W'(j)) ? q_item.ch : pend_q[j];
		end
		n_eff = appending ? pcnt_q + 1'b1 : pcnt_q;
		c     = pe[0];
	end

	// parallel compare against the symbol table; lowest entry wins
	always_comb begin
		logic pm;
		hold      = 1'b0;
		hit_found = 1'b0;
		hit_idx   = '0;
		hit_len   = '0;
		for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
			pm = 1'b1;
			for (int j = 0; j < MAX_SYMBOL_BYTES; j++) begin
				if (PCNT_W'(j) < n_eff && SLEN_W'(j) < SYM_LEN[i]) begin
					pm = pm && (pe[j].data == SYM_BYTES[i][j]);
				end
			end
			if (pm && SYM_LEN[i] > n_eff) begin
				hold = 1'b1;
			end
			if (pm && SYM_LEN[i] <= n_eff) begin
				hit_found = 1'b1;
				hit_idx   = KIND_W'(i);
				hit_len   = SYM_LEN[i];
			end
		end
	end

	// pick the one resolve step for this cycle
	always_comb begin
		act = ACT_NONE;
		if (start_end) begin
			act = ACT_END_START;
		end else if (active) begin
			if (n_eff == '0) begin
				act = (mode_q == MODE_IDENT || mode_q == MODE_NUMBER) ?
					ACT_FLUSH_RUN : ACT_END_TOK;
			end else begin
				unique case (mode_q)
					MODE_IDENT: begin
						act = ident_cont(c.cls) ? ACT_RUN_ADV : ACT_RUN_END;
					end
					MODE_NUMBER: begin
						act = (c.cls == CLS_DIGIT) ? ACT_RUN_ADV : ACT_RUN_END;
					end
					MODE_COMMENT: begin
						act = (c.cls == CLS_NEWLINE) ? ACT_CMT_END : ACT_CMT_ADV;
					end
					MODE_IDLE: begin
						if (hold && !final_q) begin
							act = ACT_HOLD;
						end else if (hit_found) begin
							act = ACT_SYM;
						end else begin
							unique case (c.cls)
								CLS_SPACE:              act = ACT_SPACE;
								CLS_NEWLINE:            act = ACT_NEWLINE;
								CLS_HASH:               act = ACT_HASH;
								CLS_ALPHA, CLS_UNDER:   act = ACT_START_ID;
								CLS_DIGIT:              act = ACT_START_NUM;
								CLS_OTHER, CLS_IDPUNCT: act = ACT_LITERAL;
								default:                act = ACT_LITERAL;
							endcase
						end
					end
					default: act = ACT_NONE;
				endcase
			end
		end
	end

	assign out_room = !tok_valid_q || !tok_stall;
	assign advance  = (act != ACT_NONE) && (!emit_v || out_room);
	assign q_pop    = advance && (appending || start_end);

	assign step_k  = (act == ACT_SYM) ? hit_len : SLEN_W'(1);
	assign col_sum = {1'b0, col_q} + (COL_W+1)'(step_k);
	assign col_adv = col_sum[COL_W] ? '1 : col_sum[COL_W-1:0];
	assign off_adv = off_q + OFF_W'(step_k);

	always_comb begin
		unique case (act)
			ACT_SYM: drop_k = PCNT_W'(hit_len);
			ACT_RUN_ADV, ACT_CMT_ADV, ACT_SPACE, ACT_NEWLINE, ACT_HASH,
			ACT_START_ID, ACT_START_NUM, ACT_LITERAL: drop_k = PCNT_W'(1);
			default: drop_k = '0;
		endcase
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		final_d    = final_q;
		line_d     = line_q;
		col_d      = col_q;
		off_d      = off_q;
		run_line_d = run_line_q;
		run_col_d  = run_col_q;
		run_off_d  = run_off_q;
		run_len_d  = run_len_q;
		for (int j = 0; j < MAX_SYMBOL_BYTES; j++) begin
			pend_d[j] = pe[j];
			for (int kk = 1; kk <= MAX_SYMBOL_BYTES; kk++) begin
				if (drop_k == PCNT_W'(kk) && j + kk < MAX_SYMBOL_BYTES) begin
					pend_d[j] = pe[j + kk];
				end
			end
		end
		pcnt_d = n_eff - drop_k;
		unique case (act)
			ACT_RUN_ADV: begin
				if (run_len_q != '1) begin
					run_len_d = run_len_q + 1'b1;
				end
				col_d = col_adv;
				off_d = off_adv;
			end
			ACT_RUN_END, ACT_FLUSH_RUN, ACT_CMT_END: begin
				mode_d = MODE_IDLE;
			end
			ACT_CMT_ADV: begin
				off_d = off_adv;
			end
			ACT_SYM, ACT_SPACE, ACT_LITERAL: begin
				col_d = col_adv;
				off_d = off_adv;
			end
			ACT_NEWLINE: begin
				if (line_q != '1) begin
					line_d = line_q + 1'b1;
				end
				col_d = COL_W'(1);
				off_d = off_adv;
			end
			ACT_HASH: begin
				mode_d = MODE_COMMENT;
				off_d  = off_adv;
			end
			ACT_START_ID, ACT_START_NUM: begin
				mode_d     = (act == ACT_START_ID) ? MODE_IDENT : MODE_NUMBER;
				run_line_d = line_q;
				run_col_d  = col_q;
				run_off_d  = off_q;
				run_len_d  = LEN_W'(1);
				col_d      = col_adv;
				off_d      = off_adv;
			end
			ACT_END_START: begin
				final_d = 1'b1;
			end
			ACT_END_TOK: begin
				pcnt_d     = '0;
				mode_d     = MODE_IDLE;
				final_d    = 1'b0;
				line_d     = LINE_W'(1);
				col_d      = COL_W'(1);
				off_d      = '0;
				run_line_d = LINE_W'(1);
				run_col_d  = COL_W'(1);
				run_off_d  = '0;
				run_len_d  = '0;
			end
			default: ;
		endcase
		if (act == ACT_END_START) begin
			busy_d = 1'b1;
		end else if (act == ACT_END_TOK) begin
			busy_d = 1'b0;
		end else if (final_q) begin
			busy_d = 1'b1;
		end else begin
			busy_d = (pcnt_d != '0) && (act != ACT_HOLD);
		end
	end

	// token produced by this step
	always_comb begin
		emit_v                 = 1'b0;
		emit_item.token_kind   = KIND_LITERAL;
		emit_item.start_line   = line_q;
		emit_item.start_column = col_q;
		emit_item.start_offset = off_q;
		emit_item.token_length = LEN_W'(1);
		emit_item.last_token   = 1'b0;
		unique case (act)
			ACT_RUN_END, ACT_FLUSH_RUN: begin
				emit_v                 = 1'b1;
				emit_item.token_kind   = (mode_q == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
				emit_item.start_line   = run_line_q;
				emit_item.start_column = run_col_q;
				emit_item.start_offset = run_off_q;
				emit_item.token_length = run_len_q;
			end
			ACT_SYM: begin
				emit_v                 = 1'b1;
				emit_item.token_kind   = KIND_SYM_BASE + hit_idx;
				emit_item.token_length = LEN_W'(hit_len);
			end
			ACT_LITERAL: begin
				emit_v = 1'b1;
			end
			ACT_END_TOK: begin
				emit_v                 = 1'b1;
				emit_item.token_kind   = KIND_END;
				emit_item.token_length = '0;
				emit_item.last_token   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int j = 0; j < MAX_SYMBOL_BYTES; j++) begin
				pend_q[j] <= pend_d[j];
			end
			run_line_q <= run_line_d;
			run_col_q  <= run_col_d;
			run_off_q  <= run_off_d;
			run_len_q  <= run_len_d;
		end
		if (advance && emit_v) begin
			tok_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			mode_q      <= MODE_IDLE;
			busy_q      <= 1'b0;
			final_q     <= 1'b0;
			line_q      <= LINE_W'(1);
			col_q       <= COL_W'(1);
			off_q       <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pcnt_q  <= pcnt_d;
				mode_q  <= mode_d;
				busy_q  <= busy_d;
				final_q <= final_d;
				line_q  <= line_d;
				col_q   <= col_d;
				off_q   <= off_d;
			end
			if (advance && emit_v) begin
				tok_valid_q <= 1'b1;
			end else if (!tok_stall) begin
				tok_valid_q <= 1'b0;
			end
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok_item  = tok_q;

endmodule

// ===== sv/lmst_checker.sv =====
`timescale 1ns / 1ps
module lmst_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                tok_valid,
	input logic                tok_stall,
	input lmst_pkg::tok_item_t tok_item
);
	import lmst_pkg::*;

	// hold a stalled transaction
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(tok_item))
		else $error("token changed while stalled");

	a_end_tok: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> ((tok_item.token_kind == KIND_END) == tok_item.last_token) &&
			(!tok_item.last_token || tok_item.token_length == '0))
		else $error("end token malformed");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok_item.token_kind <= KIND_SYM_LAST)
		else $error("token kind out of range");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_item.token_kind >= KIND_LITERAL |->
			tok_item.token_length >= LEN_W'(1) &&
			tok_item.token_length <= LEN_W'(MAX_SYMBOL_BYTES))
		else $error("symbol or literal length out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok_item.start_line != '0 && tok_item.start_column != '0)
		else $error("line or column is zero");

endmodule

bind longest_match_symbol_tokenizer_top lmst_checker u_lmst_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import lmst_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	src_item_t src_item;
	logic      tok_valid;
	logic      tok_stall;
	tok_item_t tok_item;

	longest_match_symbol_tokenizer_top DUT (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall), .src_item(src_item),
		.tok_valid(tok_valid), .tok_stall(tok_stall), .tok_item(tok_item)
	);

	// predictor state
	logic [7:0]        held [MAX_SYMBOL_BYTES];
	int                held_n;
	mode_t             scan;
	logic [LINE_W-1:0] cur_line;
	logic [COL_W-1:0]  cur_col;
	logic [OFF_W-1:0]  cur_off;
	logic [LINE_W-1:0] run_line;
	logic [COL_W-1:0]  run_col;
	logic [OFF_W-1:0]  run_off;
	logic [LEN_W-1:0]  run_len;

	tok_item_t expected_tokens[$];
	int        mismatches;
	int        tokens_seen;
	int        bytes_sent;
	int        streams_sent;
	bit        src_idle_on;
	bit        tok_stall_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void clear_state();
		held_n   = 0;
		scan     = MODE_IDLE;
		cur_line = 1;
		cur_col  = 1;
		cur_off  = 0;
		run_line = 1;
		run_col  = 1;
		run_off  = 0;
		run_len  = 0;
		for (int i = 0; i < MAX_SYMBOL_BYTES; i++) held[i] = 8'h00;
	endfunction

	function automatic void push_token(logic [KIND_W-1:0] k, logic [LINE_W-1:0] ln,
			logic [COL_W-1:0] cl, logic [OFF_W-1:0] of, logic [LEN_W-1:0] len, logic lst);
		tok_item_t t;
		t.token_kind   = k;
		t.start_line   = ln;
		t.start_column = cl;
		t.start_offset = of;
		t.token_length = len;
		t.last_token   = lst;
		expected_tokens.push_back(t);
	endfunction

	function automatic void col_step(int k);
		if (int'(cur_col) + k > 16'hFFFF) cur_col = 16'hFFFF;
		else cur_col = cur_col + COL_W'(k);
	endfunction

	function automatic void shift_held(int k);
		if (k >= held_n) begin
			held_n = 0;
			return;
		end
		for (int i = 0; i < MAX_SYMBOL_BYTES - k; i++) held[i] = held[i + k];
		held_n -= k;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit sym_prefix_eq(int s, int n);
		for (int j = 0; j < n; j++)
			if (SYM_BYTES[s][j] != held[j]) return 0;
		return 1;
	endfunction

	function automatic void flush_run();
		push_token(scan == MODE_IDENT ? KIND_IDENT : KIND_NUMBER,
			run_line, run_col, run_off, run_len, 1'b0);
	endfunction

	function automatic void resolve_held(bit at_end);
		logic [7:0] c;
		int hit;
		bit cont;
		while (held_n > 0) begin
			c = held[0];
			hit = -1;
			if (scan == MODE_IDENT || scan == MODE_NUMBER) begin
				cont = (scan == MODE_IDENT) ?
					(is_alpha(c) || is_num(c) || c == CH_UNDER || c == CH_DASH || c == CH_DOT)
					: is_num(c);
				if (cont) begin
					if (run_len != 16'hFFFF) run_len++;
					col_step(1);
					cur_off++;
					shift_held(1);
				end else begin
					flush_run();
					scan = MODE_IDLE;
				end
				continue;
			end
			if (scan == MODE_COMMENT) begin
				if (c == CH_NL) scan = MODE_IDLE;
				else begin
					cur_off++;
					shift_held(1);
				end
				continue;
			end
			if (!at_end)
				for (int s = 0; s < NUM_SYMBOLS; s++)
					if (int'(SYM_LEN[s]) > held_n && sym_prefix_eq(s, held_n)) return;
			for (int s = 0; s < NUM_SYMBOLS; s++)
				if (int'(SYM_LEN[s]) <= held_n && sym_prefix_eq(s, SYM_LEN[s])) begin
					hit = s;
					break;
				end
			if (hit >= 0) begin
				push_token(KIND_W'(int'(KIND_SYM_BASE) + hit), cur_line, cur_col, cur_off,
					LEN_W'(SYM_LEN[hit]), 1'b0);
				col_step(SYM_LEN[hit]);
				cur_off += OFF_W'(SYM_LEN[hit]);
				shift_held(SYM_LEN[hit]);
				continue;
			end
			shift_held(1);
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
				if (c == CH_NL) begin
					if (cur_line != 16'hFFFF) cur_line++;
					cur_col = 1;
				end else col_step(1);
				cur_off++;
			end else if (c == CH_HASH) begin
				scan = MODE_COMMENT;
				cur_off++;
			end else if (is_alpha(c) || c == CH_UNDER || is_num(c)) begin
				scan     = is_num(c) ? MODE_NUMBER : MODE_IDENT;
				run_line = cur_line;
				run_col  = cur_col;
				run_off  = cur_off;
				run_len  = 1;
				col_step(1);
				cur_off++;
			end else begin
				push_token(KIND_LITERAL, cur_line, cur_col, cur_off, LEN_W'(1), 1'b0);
				col_step(1);
				cur_off++;
			end
		end
	endfunction

	function automatic void predict_tokens(src_item_t it);
		if (it.end_mark) begin
			resolve_held(1);
			if (scan == MODE_IDENT || scan == MODE_NUMBER) flush_run();
			push_token(KIND_END, cur_line, cur_col, cur_off, '0, 1'b1);
			clear_state();
			return;
		end
		if (held_n < MAX_SYMBOL_BYTES) begin
			held[held_n] = it.byte_in;
			held_n++;
		end
		resolve_held(0);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t token %0d %s: got %0h expected %0h", $time, tokens_seen,
			what, got, want);
		mismatches++;
	endtask

	// send one byte (or end mark); idle bursts before it when enabled
	task automatic send_byte(logic [7:0] b, logic em);
		src_item_t it;
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		it.byte_in  = em ? 8'($urandom) : b;
		it.end_mark = em;
		src_valid <= 1'b1;
		src_item  <= it;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		predict_tokens(it);
		if (em) streams_sent++;
		else bytes_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	task automatic send_seq(logic [7:0] q[$]);
		foreach (q[i]) send_byte(q[i], 1'b0);
	endtask

	// check every accepted token
	always @(posedge clk) begin
		if (arst_n && tok_valid && !tok_stall) begin
			if (expected_tokens.size() == 0) begin
				$display("ERROR %0t unexpected token kind %0d", $time, tok_item.token_kind);
				mismatches++;
			end else begin
				tok_item_t w;
				w = expected_tokens.pop_front();
				if (tok_item.token_kind != w.token_kind)
					report_mismatch("kind", tok_item.token_kind, w.token_kind);
				if (tok_item.start_line != w.start_line)
					report_mismatch("line", tok_item.start_line, w.start_line);
				if (tok_item.start_column != w.start_column)
					report_mismatch("column", tok_item.start_column, w.start_column);
				if (tok_item.start_offset != w.start_offset)
					report_mismatch("offset", tok_item.start_offset, w.start_offset);
				if (tok_item.token_length != w.token_length)
					report_mismatch("length", tok_item.token_length, w.token_length);
				if (tok_item.last_token != w.last_token)
					report_mismatch("last", tok_item.last_token, w.last_token);
			end
			tokens_seen++;
		end
	end

	// output stall bursts
	initial begin
		tok_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (tok_stall_on && $urandom_range(0, 4) == 0) begin
				tok_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				tok_stall <= 1'b0;
			end
		end
	end

	task automatic test_symbols();
		logic [7:0] q[$];
		// every table entry, space separated, so longest match picks each one
		for (int s = 0; s < NUM_SYMBOLS; s++) begin
			q = {};
			for (int j = 0; j < int'(SYM_LEN[s]); j++) q.push_back(SYM_BYTES[s][j]);
			send_seq(q);
			send_byte(CH_SPACE, 1'b0);
		end
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_directed();
		// runs, comments, literals, zero and high bytes, held prefix flushed at end
		send_text("ab_9-.x 0123 _z\t#c");
		send_byte(8'hAB, 1'b0);
		send_text("\n!");
		send_byte(8'h00, 1'b0);
		send_seq({8'hFF, 8'hC2, 8'hAB, 8'hC2});
		send_byte(8'h00, 1'b1);
		send_text("id#open");
		send_byte(8'h00, 1'b1);
		send_text(";;;");
		send_seq({8'hE2, 8'h8A, 8'h95, 8'hC2, 8'hB6, 8'hC2, 8'hB6,
			8'hC2, 8'hAB, 8'hC2, 8'hAB, 8'hC2, 8'hAB});
		send_text("77");
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b1);
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return SYM_BYTES[$urandom_range(0, NUM_SYMBOLS - 1)][$urandom_range(0, 2)];
		if (r < 50) return 8'("a" + $urandom_range(0, 25));
		if (r < 62) return 8'("0" + $urandom_range(0, 9));
		if (r < 72) return CH_SPACE;
		if (r < 78) return CH_NL;
		if (r < 82) return CH_HASH;
		if (r < 88) return 8'($urandom_range(CH_DASH, CH_DOT));
		return 8'($urandom);
	endfunction

	task automatic test_random(int n);
		logic [7:0] q[$];
		int s;
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 1)) begin
				s = $urandom_range(0, NUM_SYMBOLS - 1);
				q = {};
				for (int j = 0; j < int'(SYM_LEN[s]); j++) q.push_back(SYM_BYTES[s][j]);
				send_seq(q);
				sent += q.size();
			end else begin
				send_byte(pick_byte(), 1'b0);
				sent++;
			end
			if ($urandom_range(0, 40) == 0) send_byte(8'h00, 1'b1);
		end
		send_byte(8'h00, 1'b1);
	endtask

	initial begin : timeout
		#8ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int w;
		mismatches   = 0;
		tokens_seen  = 0;
		bytes_sent   = 0;
		streams_sent = 0;
		src_idle_on  = 1'b1;
		tok_stall_on = 1'b1;
		clear_state();
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_item  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_symbols();
		test_directed();
		test_random(180);
		src_idle_on  = 1'b0;
		tok_stall_on = 1'b0;
		test_random(50);
		src_valid <= 1'b0;
		w = 0;
		while (expected_tokens.size() != 0 && w < 20000) begin
			@(posedge clk);
			w++;
		end
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes in %0d streams; checked %0d tokens.",
			bytes_sent, streams_sent, tokens_seen);
		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/lmst_pkg.sv
sv/lmst_front.sv
sv/lmst_back.sv
sv/longest_match_symbol_tokenizer_top.sv
sv/lmst_checker.sv
sim/tb.sv
